/* hdl/coap_message_parser_macros.svh */
// ----------------------------------------------------------------------------
// CoAP message parser assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef COAP_MESSAGE_PARSER_MACROS_SVH
`define COAP_MESSAGE_PARSER_MACROS_SVH

// implication checked every clock, off during reset
`define CMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/cmp_pkg.sv */
// ----------------------------------------------------------------------------
// CoAP parser package
// Shared widths, codes and the classified-beat record.
// ----------------------------------------------------------------------------
package cmp_pkg;

  localparam int unsigned MaxOptions    = 16;
  localparam int unsigned MaxTokenBytes = 8;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [2:0] KindHeader  = 3'd0;
  localparam logic [2:0] KindToken   = 3'd1;
  localparam logic [2:0] KindOptStart = 3'd2;
  localparam logic [2:0] KindOptByte = 3'd3;
  localparam logic [2:0] KindPayload = 3'd4;
  localparam logic [2:0] KindAccept  = 3'd5;
  localparam logic [2:0] KindReject  = 3'd6;

  localparam logic [3:0] ErrNone       = 4'd0;
  localparam logic [3:0] ErrShortHdr   = 4'd1;
  localparam logic [3:0] ErrVersion    = 4'd2;
  localparam logic [3:0] ErrTokenLen   = 4'd3;
  localparam logic [3:0] ErrEmptyCode  = 4'd4;
  localparam logic [3:0] ErrShortToken = 4'd5;
  localparam logic [3:0] ErrShortOpt   = 4'd6;
  localparam logic [3:0] ErrNibble15   = 4'd7;
  localparam logic [3:0] ErrDeltaBig   = 4'd8;
  localparam logic [3:0] ErrOverrun    = 4'd9;
  localparam logic [3:0] ErrTooMany    = 4'd10;
  localparam logic [3:0] ErrMarker     = 4'd11;

  localparam int unsigned OutBits = 3 + 8 + 2 + 4 + 8 + 16 + 16 + 16 + 5 + 4 + 1;
  localparam int unsigned OutDataBits = ((OutBits - 3 + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  message_type;
    logic [3:0]  token_length;
    logic [7:0]  code_byte;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [4:0]  options_seen;
    logic [3:0]  error_code;
    logic        last_result;
  } result_t;

  // one classified input byte: up to two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

/* hdl/coap_message_parser.sv */
// ----------------------------------------------------------------------------
// CoAP message parser
// Byte-stream CoAP/UDP datagram parser with header, token, option and payload
// results and an accept or reject verdict per packet.
//
//   channel | dir | beat contents
//   s_axis  | in  | tdata: data_byte; tlast: end_of_packet
//   m_axis  | out | tuser: item_kind; tdata: result fields
//   cfg     | in  | transport_is_udp
//
// One byte per cycle is accepted while the queue has room; the front parse
// results are combinational. A byte with two results costs two output beats.
// Reset gives header phase, UDP transport and an empty queue.
// Output stalls fill the four-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module coap_message_parser #(
  parameter int unsigned MAX_OPTIONS     = cmp_pkg::MaxOptions,
  parameter int unsigned MAX_TOKEN_BYTES = cmp_pkg::MaxTokenBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // byte_value, message_type, token_length, code_byte, message_id,
  // option_number, option_length, options_seen, error_code, last_result
  output logic [cmp_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic [2:0]                      m_axis_tuser   // item_kind
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmp_pkg::entry_t f_entry, q_entry;
  logic f_empty;

  cmp_front #(.MAX_OPTIONS(MAX_OPTIONS), .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_eop_i(s_axis_tlast),
    .q_ready_i(f_ready), .q_valid_o(f_valid), .q_entry_o(f_entry)
  );

  // beats without results (r0 last flag clear, no r1) have nothing to queue
  assign f_empty = !f_entry.r0.last_result && !f_entry.two;

  cmp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_empty_i(f_empty),
    .wr_entry_i(f_entry), .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_entry_o(q_entry)
  );

  cmp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_entry_i(q_entry),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_o(m_axis_tdata), .m_tuser_o(m_axis_tuser)
  );

endmodule

/* hdl/cmp_front.sv */
// ----------------------------------------------------------------------------
// CoAP parser front end
// Runs the per-byte parse state and emits the results of each byte.
// ----------------------------------------------------------------------------
module cmp_front #(
  parameter int unsigned MAX_OPTIONS     = cmp_pkg::MaxOptions,
  parameter int unsigned MAX_TOKEN_BYTES = cmp_pkg::MaxTokenBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eop_i,
  input  logic            q_ready_i,
  output logic            q_valid_o,
  output cmp_pkg::entry_t q_entry_o
);

  typedef enum logic [2:0] {
    PhHeader, PhToken, PhOpt, PhExt, PhValue, PhPayload, PhSkip
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  tok_q, tok_d;
  logic [7:0]  code_q, code_d, first_q, first_d;
  logic [15:0] onum_q, onum_d, acc_q, acc_d, vrem_q, vrem_d, clen_q, clen_d;
  logic [3:0]  dnib_q, dnib_d, lnib_q, lnib_d;
  // wide enough for the largest option limit; results show the low five bits
  logic [6:0]  ocnt_q, ocnt_d;
  logic        udp_q;

  logic fire;
  assign in_ready_o  = q_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign q_valid_o   = fire;

  cmp_pkg::result_t res [2];
  logic [1:0] n;

  function automatic cmp_pkg::result_t mk(logic [2:0] k, logic [7:0] b, logic [3:0] e,
                                           logic [6:0] oc);
    cmp_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.byte_value = b;
    r.error_code = e;
    r.options_seen = oc[4:0];
    return r;
  endfunction

  always_comb begin
    logic [3:0]  nib;
    logic [15:0] val, acc_n, len;
    logic        big, eop, fin, rej;
    logic [3:0]  err;
    logic [2:0]  c1;
    phase_d = phase_q; cnt_d = cnt_q; tok_d = tok_q; code_d = code_q; first_d = first_q;
    onum_d = onum_q; acc_d = acc_q; vrem_d = vrem_q; clen_d = clen_q;
    dnib_d = dnib_q; lnib_d = lnib_q; ocnt_d = ocnt_q;
    res[0] = '0; res[1] = '0; n = 2'd0;
    eop = in_eop_i; fin = 1'b0; rej = 1'b0; err = cmp_pkg::ErrNone;
    nib = '0; val = '0; acc_n = '0; len = '0; big = 1'b0; c1 = '0;
    // fin: emit option start with len; rej: emit reject err after res so far
    unique case (phase_q)
      PhHeader: begin
        if (cnt_q == 3'd0 && !udp_q) begin
          rej = 1'b1;
        end else begin
          if (cnt_q == 3'd0) first_d = in_byte_i;
          else if (cnt_q == 3'd1) code_d = in_byte_i;
          else if (cnt_q == 3'd2) acc_d = {in_byte_i, 8'h00};
          else acc_d = {acc_q[15:8], in_byte_i};
          if (cnt_q < 3'd3) begin
            cnt_d = cnt_q + 3'd1;
            if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortHdr; end
          end else if (first_q[7:6] != 2'd1) begin
            rej = 1'b1; err = cmp_pkg::ErrVersion;
          end else if (32'(first_q[3:0]) > MAX_TOKEN_BYTES) begin
            rej = 1'b1; err = cmp_pkg::ErrTokenLen;
          end else if (code_q == 8'd0 && !eop) begin
            rej = 1'b1; err = cmp_pkg::ErrEmptyCode;
          end else begin
            res[0] = mk(cmp_pkg::KindHeader, 8'd0, cmp_pkg::ErrNone, ocnt_q);
            res[0].message_type = first_q[5:4];
            res[0].token_length = first_q[3:0];
            res[0].code_byte = code_q;
            res[0].message_id = {acc_q[15:8], in_byte_i};
            n = 2'd1;
            cnt_d = '0; acc_d = '0; tok_d = first_q[3:0];
            if (first_q[3:0] != 4'd0) begin
              phase_d = PhToken;
              if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortToken; end
            end else phase_d = PhOpt;
          end
        end
      end
      PhToken: begin
        res[0] = mk(cmp_pkg::KindToken, in_byte_i, cmp_pkg::ErrNone, ocnt_q);
        n = 2'd1;
        tok_d = tok_q - 4'd1;
        if (tok_d == 4'd0) phase_d = PhOpt;
        else if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortToken; end
      end
      PhOpt: begin
        if (in_byte_i == 8'hFF) begin
          phase_d = PhPayload;
          if (eop) begin rej = 1'b1; err = cmp_pkg::ErrMarker; end
        end else if (32'(ocnt_q) >= MAX_OPTIONS) begin
          rej = 1'b1; err = cmp_pkg::ErrTooMany;
        end else begin
          dnib_d = in_byte_i[7:4]; lnib_d = in_byte_i[3:0];
          cnt_d = '0; acc_d = '0;
          if (in_byte_i[7:4] == 4'd15) begin
            rej = 1'b1; err = cmp_pkg::ErrNibble15;
          end else if (in_byte_i[7:4] < 4'd13) begin
            onum_d = onum_q + 16'(in_byte_i[7:4]);
            dnib_d = '0;
            if (in_byte_i[3:0] == 4'd15) begin
              rej = 1'b1; err = cmp_pkg::ErrNibble15;
            end else if (in_byte_i[3:0] < 4'd13) begin
              fin = 1'b1; len = 16'(in_byte_i[3:0]);
            end else begin
              phase_d = PhExt;
              if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortOpt; end
            end
          end else begin
            phase_d = PhExt;
            if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortOpt; end
          end
        end
      end
      PhExt: begin
        nib = (dnib_q >= 4'd13) ? dnib_q : lnib_q;
        acc_n = {acc_q[7:0], in_byte_i};
        acc_d = acc_n;
        c1 = cnt_q + 3'd1;
        cnt_d = c1;
        if (c1 < ((nib == 4'd13) ? 3'd1 : 3'd2)) begin
          if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortOpt; end
        end else begin
          big = (nib != 4'd13) && (acc_n > 16'd65266);
          val = (nib == 4'd13) ? (16'(acc_n[7:0]) + 16'd13) : (acc_n + 16'd269);
          if (big) begin
            rej = 1'b1; err = cmp_pkg::ErrDeltaBig;
          end else if (dnib_q >= 4'd13) begin
            onum_d = onum_q + val;
            dnib_d = '0; cnt_d = '0; acc_d = '0;
            if (lnib_q == 4'd15) begin
              rej = 1'b1; err = cmp_pkg::ErrNibble15;
            end else if (lnib_q < 4'd13) begin
              fin = 1'b1; len = 16'(lnib_q);
            end else begin
              phase_d = PhExt;
              if (eop) begin rej = 1'b1; err = cmp_pkg::ErrShortOpt; end
            end
          end else begin
            cnt_d = '0; acc_d = '0;
            fin = 1'b1; len = val;
          end
        end
      end
      PhValue: begin
        res[0] = mk(cmp_pkg::KindOptByte, in_byte_i, cmp_pkg::ErrNone, ocnt_q);
        res[0].option_number = onum_q;
        res[0].option_length = clen_q;
        n = 2'd1;
        vrem_d = vrem_q - 16'd1;
        if (vrem_d == 16'd0) phase_d = PhOpt;
        else if (eop) begin rej = 1'b1; err = cmp_pkg::ErrOverrun; end
      end
      PhPayload: begin
        res[0] = mk(cmp_pkg::KindPayload, in_byte_i, cmp_pkg::ErrNone, ocnt_q);
        n = 2'd1;
      end
      PhSkip: begin
      end
      default: begin
      end
    endcase

    if (fin) begin
      ocnt_d = ocnt_q + 7'd1;
      clen_d = len; vrem_d = len;
      res[0] = mk(cmp_pkg::KindOptStart, 8'd0, cmp_pkg::ErrNone, ocnt_d);
      res[0].option_number = onum_d;
      res[0].option_length = len;
      n = 2'd1;
      phase_d = (len == 16'd0) ? PhOpt : PhValue;
      if (len != 16'd0 && eop) begin rej = 1'b1; err = cmp_pkg::ErrOverrun; end
    end

    if (phase_q == PhSkip) begin
      n = 2'd0;
      if (eop) phase_d = PhHeader;
    end else if (rej) begin
      res[n[0]] = mk(cmp_pkg::KindReject, 8'd0, err, ocnt_d);
      n = n + 2'd1;
      phase_d = eop ? PhHeader : PhSkip;
    end else if (eop && phase_d != PhHeader) begin
      // a complete unit ended the packet: accept
      res[n[0]] = mk(cmp_pkg::KindAccept, 8'd0, cmp_pkg::ErrNone, ocnt_d);
      n = n + 2'd1;
      phase_d = PhHeader;
    end else if (eop) begin
      phase_d = PhHeader;
    end

    if (phase_d == PhHeader && eop) begin
      cnt_d = '0; tok_d = '0; code_d = '0; first_d = '0; onum_d = '0; acc_d = '0;
      vrem_d = '0; clen_d = '0; dnib_d = '0; lnib_d = '0; ocnt_d = '0;
    end
    // last flag only on a real result, so an empty beat stays all zero
    if (n == 2'd2) res[1].last_result = 1'b1;
    else if (n == 2'd1) res[0].last_result = 1'b1;
  end

  always_comb begin
    q_entry_o.two = (n == 2'd2);
    q_entry_o.r0 = res[0];
    q_entry_o.r1 = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; cnt_q <= '0; tok_q <= '0; code_q <= '0; first_q <= '0;
      onum_q <= '0; acc_q <= '0; vrem_q <= '0; clen_q <= '0; dnib_q <= '0;
      lnib_q <= '0; ocnt_q <= '0; udp_q <= 1'b1;
    end else begin
      if (cfg_valid_i) udp_q <= cfg_data_i;
      if (fire) begin
        phase_q <= phase_d; cnt_q <= cnt_d; tok_q <= tok_d; code_q <= code_d;
        first_q <= first_d; onum_q <= onum_d; acc_q <= acc_d; vrem_q <= vrem_d;
        clen_q <= clen_d; dnib_q <= dnib_d; lnib_q <= lnib_d; ocnt_q <= ocnt_d;
      end
    end
  end

endmodule

/* hdl/cmp_queue.sv */
// ----------------------------------------------------------------------------
// CoAP parser result queue
// Small FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module cmp_queue #(
  parameter int unsigned DEPTH = cmp_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  logic            wr_empty_i,
  input  cmp_pkg::entry_t wr_entry_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output cmp_pkg::entry_t rd_entry_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmp_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic push, pop;

  assign wr_ready_o = (32'(cnt_q) < DEPTH);
  assign push = wr_valid_i && wr_ready_o && !wr_empty_i;
  assign rd_valid_o = (cnt_q != '0);
  assign pop = rd_valid_o && rd_ready_i;
  assign rd_entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* hdl/cmp_back.sv */
// ----------------------------------------------------------------------------
// CoAP parser back end
// Issues the one or two results of each queued beat on the output stream.
// ----------------------------------------------------------------------------
module cmp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  cmp_pkg::entry_t                  q_entry_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [cmp_pkg::OutDataBits-1:0]  m_tdata_o,
  output logic [2:0]                       m_tuser_o
);

  logic sel_q;
  cmp_pkg::result_t r;

  assign r = sel_q ? q_entry_i.r1 : q_entry_i.r0;
  assign m_tvalid_o = q_valid_i;
  assign q_ready_o = m_tready_i && (sel_q || !q_entry_i.two);
  assign m_tuser_o = r.kind;
  assign m_tdata_o = cmp_pkg::OutDataBits'({r.last_result, r.error_code, r.options_seen,
                      r.option_length, r.option_number, r.message_id, r.code_byte,
                      r.token_length, r.message_type, r.byte_value});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_q <= 1'b0;
    else if (q_valid_i && m_tready_i) sel_q <= q_entry_i.two && !sel_q;
  end

endmodule

/* hdl/cmp_checker.sv */
// ----------------------------------------------------------------------------
// CoAP parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "coap_message_parser_macros.svh"

module cmp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cmp_pkg::OutDataBits-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser
);

  logic [3:0] err;
  assign err = m_axis_tdata[78:75];

  `CMP_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CMP_ASSERT_IMP(a_verdict_last, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == cmp_pkg::KindAccept ||
    m_axis_tuser == cmp_pkg::KindReject), m_axis_tdata[79])
  `CMP_ASSERT_IMP(a_err_on_reject, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser != cmp_pkg::KindReject, err == cmp_pkg::ErrNone)
  `CMP_ASSERT_IMP(a_kind_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser != 3'd7)

endmodule

bind coap_message_parser cmp_checker u_checker (.*);

/* tb/sv/coap_message_parser_tb.sv */
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Streams directed and random CoAP/UDP datagrams a byte per beat, predicts
// every result beat with a cycle-free parser model and compares field by
// field under random source gaps, sink stalls and transport settings.
// ----------------------------------------------------------------------------
module coap_message_parser_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 24;

  typedef enum logic [2:0] {
    PhHeader, PhToken, PhOpt, PhExt, PhValue, PhPayload, PhSkip
  } parse_phase_e;

  // CoAP parser model plus the store of predicted result beats
  class parse_scoreboard;
    cmp_pkg::result_t pending_q[$];
    cmp_pkg::result_t step_q[$];
    int            errors;
    bit            udp_mode = 1'b1;
    parse_phase_e  phase;
    int            cnt;
    logic [3:0]    tokens;
    logic [7:0]    hdr_code;
    logic [7:0]    first_byte;
    logic [15:0]   opt_num;
    logic [3:0]    delta_nib;
    logic [3:0]    len_nib;
    logic [15:0]   ext_acc;
    logic [15:0]   value_left;
    logic [15:0]   cur_len;
    int            opt_count;
    bit            failed;

    function new();
      errors = 0;
      new_packet();
    endfunction

    function void new_packet();
      phase = PhHeader; cnt = 0; tokens = '0; hdr_code = '0; first_byte = '0;
      opt_num = '0; delta_nib = '0; len_nib = '0; ext_acc = '0; value_left = '0;
      cur_len = '0; opt_count = 0; failed = 1'b0;
    endfunction

    function void put(logic [2:0] kind, logic [7:0] b, logic [1:0] typ,
                      logic [3:0] tkl, logic [7:0] code, logic [15:0] mid,
                      logic [15:0] onum, logic [15:0] olen, logic [3:0] err);
      cmp_pkg::result_t r;
      r.kind = kind; r.byte_value = b; r.message_type = typ;
      r.token_length = tkl; r.code_byte = code; r.message_id = mid;
      r.option_number = onum; r.option_length = olen;
      r.options_seen = opt_count[4:0]; r.error_code = err; r.last_result = 1'b0;
      step_q.push_back(r);
    endfunction

    function void reject(logic [3:0] err, bit eop);
      put(cmp_pkg::KindReject, '0, '0, '0, '0, '0, '0, '0, err);
      if (eop) new_packet();
      else begin
        failed = 1'b1;
        phase = PhSkip;
      end
    endfunction

    function void accept();
      put(cmp_pkg::KindAccept, '0, '0, '0, '0, '0, '0, '0, cmp_pkg::ErrNone);
      new_packet();
    endfunction

    function void finish_option(logic [15:0] len, bit eop);
      opt_count++;
      cur_len = len;
      value_left = len;
      put(cmp_pkg::KindOptStart, '0, '0, '0, '0, '0, opt_num, len, cmp_pkg::ErrNone);
      if (len == 16'd0) begin
        phase = PhOpt;
        if (eop) accept();
      end else begin
        phase = PhValue;
        if (eop) reject(cmp_pkg::ErrOverrun, 1'b1);
      end
    endfunction

    function void after_delta(bit eop);
      cnt = 0;
      ext_acc = '0;
      if (len_nib == 4'd15) reject(cmp_pkg::ErrNibble15, eop);
      else if (len_nib < 4'd13) finish_option({12'd0, len_nib}, eop);
      else begin
        phase = PhExt;
        if (eop) reject(cmp_pkg::ErrShortOpt, 1'b1);
      end
    endfunction

    function void set_transport(bit v);
      udp_mode = v;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    // one accepted input beat
    function void note_byte(logic [7:0] b, bit eop);
      logic [3:0]  nib;
      int          need;
      logic [15:0] val;
      bit          ok;
      step_q.delete();
      if (failed || phase == PhSkip) begin
        if (eop) new_packet();
        return;
      end
      case (phase)
        PhHeader: begin
          if (cnt == 0 && !udp_mode) reject(cmp_pkg::ErrNone, eop);
          else begin
            case (cnt)
              0: first_byte = b;
              1: hdr_code = b;
              2: ext_acc = {b, 8'h00};
              default: ext_acc = ext_acc | {8'h00, b};
            endcase
            if (cnt < 3) begin
              cnt++;
              if (eop) reject(cmp_pkg::ErrShortHdr, 1'b1);
            end else if (first_byte[7:6] != 2'd1) reject(cmp_pkg::ErrVersion, eop);
            else if (first_byte[3:0] > cmp_pkg::MaxTokenBytes)
              reject(cmp_pkg::ErrTokenLen, eop);
            else if (hdr_code == 8'd0 && !eop) reject(cmp_pkg::ErrEmptyCode, 1'b0);
            else begin
              put(cmp_pkg::KindHeader, '0, first_byte[5:4], first_byte[3:0], hdr_code,
                  ext_acc, '0, '0, cmp_pkg::ErrNone);
              cnt = 0;
              ext_acc = '0;
              tokens = first_byte[3:0];
              if (tokens > 4'd0) begin
                phase = PhToken;
                if (eop) reject(cmp_pkg::ErrShortToken, 1'b1);
              end else begin
                phase = PhOpt;
                if (eop) accept();
              end
            end
          end
        end
        PhToken: begin
          put(cmp_pkg::KindToken, b, '0, '0, '0, '0, '0, '0, cmp_pkg::ErrNone);
          tokens = tokens - 4'd1;
          if (tokens == 4'd0) begin
            phase = PhOpt;
            if (eop) accept();
          end else if (eop) reject(cmp_pkg::ErrShortToken, 1'b1);
        end
        PhOpt: begin
          if (b == 8'hFF) begin
            phase = PhPayload;
            if (eop) reject(cmp_pkg::ErrMarker, 1'b1);
          end else if (opt_count >= cmp_pkg::MaxOptions) reject(cmp_pkg::ErrTooMany, eop);
          else begin
            delta_nib = b[7:4];
            len_nib = b[3:0];
            cnt = 0;
            ext_acc = '0;
            if (delta_nib == 4'd15) reject(cmp_pkg::ErrNibble15, eop);
            else if (delta_nib < 4'd13) begin
              opt_num = opt_num + {12'd0, delta_nib};
              delta_nib = '0;
              after_delta(eop);
            end else begin
              phase = PhExt;
              if (eop) reject(cmp_pkg::ErrShortOpt, 1'b1);
            end
          end
        end
        PhExt: begin
          nib = (delta_nib >= 4'd13) ? delta_nib : len_nib;
          need = (nib == 4'd13) ? 1 : 2;
          ext_acc = {ext_acc[7:0], b};
          cnt = (cnt + 1) & 7;
          if (cnt < need) begin
            if (eop) reject(cmp_pkg::ErrShortOpt, 1'b1);
          end else begin
            ok = 1'b1;
            val = '0;
            if (nib == 4'd13) val = {8'd0, ext_acc[7:0]} + 16'd13;
            else if (ext_acc > 16'd65266) ok = 1'b0;
            else val = ext_acc + 16'd269;
            if (!ok) reject(cmp_pkg::ErrDeltaBig, eop);
            else if (delta_nib >= 4'd13) begin
              opt_num = opt_num + val;
              delta_nib = '0;
              after_delta(eop);
            end else begin
              cnt = 0;
              ext_acc = '0;
              finish_option(val, eop);
            end
          end
        end
        PhValue: begin
          put(cmp_pkg::KindOptByte, b, '0, '0, '0, '0, opt_num, cur_len, cmp_pkg::ErrNone);
          value_left = value_left - 16'd1;
          if (value_left == 16'd0) begin
            phase = PhOpt;
            if (eop) accept();
          end else if (eop) reject(cmp_pkg::ErrOverrun, 1'b1);
        end
        PhPayload: begin
          put(cmp_pkg::KindPayload, b, '0, '0, '0, '0, '0, '0, cmp_pkg::ErrNone);
          if (eop) accept();
        end
        default: if (eop) new_packet();
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].last_result = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void check_result(cmp_pkg::result_t act);
      cmp_pkg::result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: kind %0d", act.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (act.kind != e.kind) begin
        $error("item_kind: expected %0d, got %0d", e.kind, act.kind); errors++;
      end
      if (act.byte_value != e.byte_value) begin
        $error("byte_value: expected %0d, got %0d", e.byte_value, act.byte_value);
        errors++;
      end
      if (act.message_type != e.message_type) begin
        $error("message_type: expected %0d, got %0d", e.message_type, act.message_type);
        errors++;
      end
      if (act.token_length != e.token_length) begin
        $error("token_length: expected %0d, got %0d", e.token_length, act.token_length);
        errors++;
      end
      if (act.code_byte != e.code_byte) begin
        $error("code_byte: expected %0d, got %0d", e.code_byte, act.code_byte); errors++;
      end
      if (act.message_id != e.message_id) begin
        $error("message_id: expected %0d, got %0d", e.message_id, act.message_id);
        errors++;
      end
      if (act.option_number != e.option_number) begin
        $error("option_number: expected %0d, got %0d", e.option_number,
               act.option_number);
        errors++;
      end
      if (act.option_length != e.option_length) begin
        $error("option_length: expected %0d, got %0d", e.option_length,
               act.option_length);
        errors++;
      end
      if (act.options_seen != e.options_seen) begin
        $error("options_seen: expected %0d, got %0d", e.options_seen, act.options_seen);
        errors++;
      end
      if (act.error_code != e.error_code) begin
        $error("error_code: expected %0d, got %0d", e.error_code, act.error_code);
        errors++;
      end
      if (act.last_result != e.last_result) begin
        $error("last_result: expected %0d, got %0d", e.last_result, act.last_result);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic                            cfg_data_i = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = 8'd0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cmp_pkg::OutDataBits-1:0] m_axis_tdata;
  logic [2:0]                      m_axis_tuser;

  parse_scoreboard sb = new();
  int unsigned     cycle_cnt = 0;
  int              src_idle_pct = 0;
  int              sink_stall_pct = 0;
  int              hold_cycles = 0;
  int              bytes_sent = 0;
  logic [7:0]      pkt_q[$];

  coap_message_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("coap_message_parser verification failed");
      $finish;
    end
  end

  // sink: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cmp_pkg::result_t act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act.kind          = m_axis_tuser;
      act.byte_value    = m_axis_tdata[7:0];
      act.message_type  = m_axis_tdata[9:8];
      act.token_length  = m_axis_tdata[13:10];
      act.code_byte     = m_axis_tdata[21:14];
      act.message_id    = m_axis_tdata[37:22];
      act.option_number = m_axis_tdata[53:38];
      act.option_length = m_axis_tdata[69:54];
      act.options_seen  = m_axis_tdata[74:70];
      act.error_code    = m_axis_tdata[78:75];
      act.last_result   = m_axis_tdata[79];
      sb.check_result(act);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eop);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eop;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_transport(input bit v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_transport(v);
  endtask

  // random datagram, mostly well formed, some truncated or corrupted
  task automatic build_random_packet();
    int tkl, nopt, len, plen;
    logic [15:0] ext;
    pkt_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(12, 1)) pkt_q.push_back(8'($urandom_range(255)));
      return;
    end
    tkl = $urandom_range(8);
    pkt_q.push_back({2'b01, 2'($urandom_range(3)), 4'(tkl)});
    pkt_q.push_back($urandom_range(99) < 3 ? 8'd0 : 8'($urandom_range(255, 1)));
    pkt_q.push_back(8'($urandom_range(255)));
    pkt_q.push_back(8'($urandom_range(255)));
    repeat (tkl) pkt_q.push_back(8'($urandom_range(255)));
    nopt = ($urandom_range(99) < 6) ? $urandom_range(18, 14) : $urandom_range(4);
    repeat (nopt) begin
      logic [3:0] dn, ln;
      logic [7:0] dext[$];
      logic [7:0] lext[$];
      case ($urandom_range(9))
        0, 1: begin dn = 4'd13; dext.push_back(8'($urandom_range(255))); end
        2: begin
          dn = 4'd14;
          ext = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(400));
          dext.push_back(ext[15:8]); dext.push_back(ext[7:0]);
        end
        3: dn = ($urandom_range(19) == 0) ? 4'd15 : 4'($urandom_range(12));
        default: dn = 4'($urandom_range(12));
      endcase
      case ($urandom_range(19))
        0, 1, 2: begin ln = 4'd13; lext.push_back(8'($urandom_range(12))); end
        3: begin
          ln = 4'd14;
          if ($urandom_range(4) == 0) begin
            lext.push_back(8'd0); lext.push_back(8'($urandom_range(2)));
          end else begin
            lext.push_back(8'hFF); lext.push_back(8'($urandom_range(255)));
          end
        end
        4: ln = 4'd15;
        default: ln = 4'($urandom_range(4));
      endcase
      pkt_q.push_back({dn, ln});
      foreach (dext[i]) pkt_q.push_back(dext[i]);
      foreach (lext[i]) pkt_q.push_back(lext[i]);
      if (ln == 4'd13) len = int'(lext[0]) + 13;
      else if (ln == 4'd14) len = int'({lext[0], lext[1]}) + 269;
      else if (ln == 4'd15) len = 0;
      else len = int'(ln);
      if (len > 300) len = 2;
      repeat (len) pkt_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(1)) begin
      pkt_q.push_back(8'hFF);
      plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
      repeat (plen) pkt_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 12 && pkt_q.size() > 1)
      pkt_q = pkt_q[0:$urandom_range(pkt_q.size() - 2)];
    if ($urandom_range(99) < 10)
      pkt_q[$urandom_range(pkt_q.size() - 1)] = 8'($urandom_range(255));
  endtask

  initial begin
    int phase_sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_transport(1'b1);

    // directed cases
    pkt_q = '{8'h40, 8'h01, 8'hFF, 8'hFF}; send_packet();                 // plain header
    pkt_q = '{8'h70, 8'h00, 8'h00, 8'h00}; send_packet();                 // empty message
    pkt_q = '{8'h40, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00}; send_packet();  // empty code, body
    pkt_q = '{8'h40, 8'h01}; send_packet();                               // short header
    pkt_q = '{8'hC0, 8'h01, 8'h00, 8'h00}; send_packet();                 // bad version
    pkt_q = '{8'h4F, 8'h01, 8'h00, 8'h00, 8'h11}; send_packet();          // token length 15
    pkt_q = '{8'h68, 8'hFF, 8'h12, 8'h34, 8'h00, 8'h01, 8'h02, 8'h03,
              8'h04, 8'h05, 8'h06, 8'hFF}; send_packet();                 // full token
    pkt_q = '{8'h72, 8'h45, 8'hAB, 8'hCD, 8'h11}; send_packet();          // short token
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h02, 8'hFF}; send_packet();          // bare marker
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h03, 8'hF0, 8'h00}; send_packet();   // delta nibble 15
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h04, 8'h1F}; send_packet();          // length nibble 15
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h05, 8'hE0, 8'hFF, 8'h00}; send_packet(); // delta big
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h06, 8'hE0, 8'hFE, 8'hF2, 8'hD1, 8'h00,
              8'hAA, 8'hFF, 8'h5A}; send_packet();                        // wrap, ext, payload
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h07, 8'h12, 8'hAA}; send_packet();   // value overrun
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h08, 8'hD0}; send_packet();          // short option hdr
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h09, 8'hDF, 8'h00}; send_packet();   // ext before nib 15
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h0A, 8'hED, 8'h00, 8'h01}; send_packet();
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h0B};
    repeat (17) pkt_q.push_back(8'h10);
    send_packet();                                                        // too many options
    write_transport(1'b0);
    pkt_q = '{8'h40, 8'h01, 8'h00, 8'h0C, 8'hFF, 8'h01}; send_packet();
    pkt_q = '{8'h40}; send_packet();
    write_transport(1'b1);

    // random traffic across idle/stall phases
    phase_sel = 0;
    while (bytes_sent < 700) begin
      case (phase_sel % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      if (phase_sel == 1) hold_cycles = 300;
      repeat (6) begin
        build_random_packet();
        send_packet();
      end
      phase_sel++;
      if (phase_sel % 5 == 0) begin
        write_transport(1'b0);
        build_random_packet();
        send_packet();
        write_transport(1'b1);
      end else if (phase_sel % 3 == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("coap_message_parser verification clean");
    else
      $display("coap_message_parser verification failed");
    $finish;
  end

endmodule

/* coap_message_parser.f */
+incdir+hdl
hdl/cmp_pkg.sv
hdl/cmp_front.sv
hdl/cmp_queue.sv
hdl/cmp_back.sv
hdl/coap_message_parser.sv
hdl/cmp_checker.sv
tb/sv/coap_message_parser_tb.sv
